// ===== sv/fes_pkg.sv =====
`default_nettype none
package fes_pkg;
  localparam int unsigned MAX_FRAME_PIXELS_DEF = 16777216;
  localparam logic [7:0] TARGET_RESET = 8'd128;
  localparam logic [7:0] BRIGHT_LIMIT = 8'd250;
  localparam logic [7:0] DARK_LIMIT = 8'd5;
  localparam int unsigned QUOT_W = 48;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DIV_MEAN,
    ST_DIV_SQ,
    ST_DIV_HL,
    ST_DIV_SH,
    ST_VAR,
    ST_SQRT,
    ST_SCORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic div_start;
    logic [1:0] div_sel;
    logic var_calc;
    logic sqrt_start;
    logic score_calc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } status_t;

  localparam logic [1:0] SEL_MEAN = 2'd0;
  localparam logic [1:0] SEL_SQ = 2'd1;
  localparam logic [1:0] SEL_HL = 2'd2;
  localparam logic [1:0] SEL_SH = 2'd3;
endpackage
`default_nettype wire

// ===== sv/fes_ctrl.sv =====
`default_nettype none
module fes_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            in_last,
  input  wire logic            out_busy,
  input  wire fes_pkg::status_t st,
  output fes_pkg::cmd_t        cmd,
  output logic                 in_ready,
  output logic                 out_load
);
  fes_pkg::state_t state_r, state_nxt;
  logic wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fes_pkg::ST_ACC;
      wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r <= wait_nxt;
    end
  end

  // wait_r marks that the unit has been started and we await it
  always_comb begin
    state_nxt = state_r;
    wait_nxt = wait_r;
    case (state_r)
      fes_pkg::ST_ACC: if (in_fire && in_last) state_nxt = fes_pkg::ST_DIV_MEAN;
      fes_pkg::ST_DIV_MEAN, fes_pkg::ST_DIV_SQ, fes_pkg::ST_DIV_HL,
      fes_pkg::ST_DIV_SH, fes_pkg::ST_SQRT: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (!st.div_busy && !st.sqrt_busy) begin
          wait_nxt = 1'b0;
          case (state_r)
            fes_pkg::ST_DIV_MEAN: state_nxt = fes_pkg::ST_DIV_SQ;
            fes_pkg::ST_DIV_SQ: state_nxt = fes_pkg::ST_DIV_HL;
            fes_pkg::ST_DIV_HL: state_nxt = fes_pkg::ST_DIV_SH;
            fes_pkg::ST_DIV_SH: state_nxt = fes_pkg::ST_VAR;
            default: state_nxt = fes_pkg::ST_SCORE;
          endcase
        end
      end
      fes_pkg::ST_VAR: state_nxt = fes_pkg::ST_SQRT;
      fes_pkg::ST_SCORE: state_nxt = fes_pkg::ST_OUT;
      fes_pkg::ST_OUT: if (!out_busy) state_nxt = fes_pkg::ST_ACC;
      default: state_nxt = fes_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      fes_pkg::ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc_en = in_fire;
      end
      fes_pkg::ST_DIV_MEAN: begin cmd.div_start = !wait_r; cmd.div_sel = fes_pkg::SEL_MEAN; end
      fes_pkg::ST_DIV_SQ: begin cmd.div_start = !wait_r; cmd.div_sel = fes_pkg::SEL_SQ; end
      fes_pkg::ST_DIV_HL: begin cmd.div_start = !wait_r; cmd.div_sel = fes_pkg::SEL_HL; end
      fes_pkg::ST_DIV_SH: begin cmd.div_start = !wait_r; cmd.div_sel = fes_pkg::SEL_SH; end
      fes_pkg::ST_VAR: cmd.var_calc = 1'b1;
      fes_pkg::ST_SQRT: cmd.sqrt_start = !wait_r;
      fes_pkg::ST_SCORE: cmd.score_calc = 1'b1;
      fes_pkg::ST_OUT: begin
        out_load = !out_busy;
        cmd.clear = !out_busy;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/fes_datapath.sv =====
`default_nettype none
module fes_datapath #(
  parameter int unsigned MAX_FRAME_PIXELS = fes_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fes_pkg::cmd_t   cmd,
  output fes_pkg::status_t     st,
  input  wire logic [7:0]      red,
  input  wire logic [7:0]      green,
  input  wire logic [7:0]      blue,
  input  wire logic [7:0]      target,
  output logic [15:0]          mean_o,
  output logic [14:0]          contrast_o,
  output logic [14:0]          hl_o,
  output logic [14:0]          sh_o,
  output logic [14:0]          score_o
);
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + 8;
  localparam int unsigned SQ_W = CNT_W + 16;
  localparam int unsigned DW = SQ_W + 32;
  localparam int unsigned QW = fes_pkg::QUOT_W;
  localparam int unsigned DCNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_r, hcnt_r, dcnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;

  // luma: narrow 8x16 products, fine as combinational logic
  logic [24:0] luma_full;
  logic [7:0]  luma;
  assign luma_full = 25'd19595 * 25'(red) + 25'd38470 * 25'(green) + 25'd7471 * 25'(blue);
  assign luma = luma_full[23:16];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0; hcnt_r <= '0; dcnt_r <= '0; sum_r <= '0; sq_r <= '0;
    end else if (cmd.acc_en && (cnt_r < CNT_W'(MAX_FRAME_PIXELS))) begin
      cnt_r <= cnt_r + 1'b1;
      sum_r <= sum_r + SUM_W'(luma);
      sq_r <= sq_r + SQ_W'(16'(luma) * 16'(luma));
      if (luma >= fes_pkg::BRIGHT_LIMIT) hcnt_r <= hcnt_r + 1'b1;
      if (luma <= fes_pkg::DARK_LIMIT) dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // restoring divider: quotient bits one per cycle, QW bits of quotient
  logic [DW-1:0] rem_r, num_r;
  logic [QW-1:0] quo_r;
  logic [DCNT_W-1:0] dstep_r;
  logic dbusy_r;
  logic [DW-1:0] num_sel, trial;
  always_comb begin
    case (cmd.div_sel)
      fes_pkg::SEL_MEAN: num_sel = DW'(sum_r) << 16;
      fes_pkg::SEL_SQ: num_sel = DW'(sq_r) << 32;
      fes_pkg::SEL_HL: num_sel = DW'(hcnt_r) * DW'(25600);
      default: num_sel = DW'(dcnt_r) * DW'(25600);
    endcase
  end
  assign trial = {rem_r[DW-2:0], num_r[DW-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      // quotient fits QW bits; top bits of numerator shifted so that DW-QW
      // leading bits become the initial remainder
      rem_r <= DW'(num_sel >> QW);
      num_r <= num_sel << (DW - QW);
      quo_r <= '0;
      dstep_r <= DCNT_W'(QW);
    end else if (dbusy_r) begin
      num_r <= num_r << 1;
      if (trial >= DW'(cnt_r)) begin
        rem_r <= trial - DW'(cnt_r);
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      dstep_r <= dstep_r - 1'b1;
      if (dstep_r == DCNT_W'(1)) dbusy_r <= 1'b0;
    end
  end

  logic [23:0] m16_r;
  logic [47:0] e32_r;
  logic [14:0] hl_r, sh_r;
  logic        div_done_r;
  logic [1:0]  dsel_r;
  always_ff @(posedge clk) begin
    if (cmd.div_start) dsel_r <= cmd.div_sel;
    div_done_r <= dbusy_r && (dstep_r == DCNT_W'(1));
    if (div_done_r) begin
      case (dsel_r)
        fes_pkg::SEL_MEAN: m16_r <= quo_r[23:0];
        fes_pkg::SEL_SQ: e32_r <= quo_r;
        fes_pkg::SEL_HL: hl_r <= quo_r[14:0];
        default: sh_r <= quo_r[14:0];
      endcase
    end
  end
  assign st.div_busy = dbusy_r || div_done_r;

  // variance: 24x24 multiply, registered, then a combinational subtract
  logic [47:0] msq_r;
  logic        var_ph_r;
  always_ff @(posedge clk) begin
    if (!rst_n) var_ph_r <= 1'b0;
    else var_ph_r <= cmd.var_calc;
    if (cmd.var_calc) msq_r <= m16_r * m16_r;
  end
  logic [47:0] var_now;
  assign var_now = (e32_r > msq_r) ? (e32_r - msq_r) : '0;

  // bit-pair square root on var>>16 (32 bits)
  logic [31:0] sx_r, sroot_r, sbit_r;
  logic        sbusy_r;
  logic [31:0] sroot_nb;
  assign sroot_nb = sroot_r + sbit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sx_r <= var_now[47:16];
      sroot_r <= '0;
      sbit_r <= 32'h4000_0000;
      sbusy_r <= 1'b1;
    end else if (sbusy_r) begin
      if (sx_r >= sroot_nb) begin
        sx_r <= sx_r - sroot_nb;
        sroot_r <= (sroot_r >> 1) + sbit_r;
      end else begin
        sroot_r <= sroot_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
      if (sbit_r == 32'd1) sbusy_r <= 1'b0;
    end
  end
  assign st.sqrt_busy = sbusy_r || var_ph_r;

  // score
  logic signed [18:0] err, pen, score;
  logic [15:0] mean8;
  logic [14:0] contrast8;
  assign mean8 = m16_r[23:8];
  assign contrast8 = sroot_r[14:0];
  always_comb begin
    err = $signed({3'b0, mean8}) - $signed({3'b0, target, 8'b0});
    if (err < 0) err = -err;
    pen = (err * 19'sd3) >>> 1;
    if (pen > 19'sd12800) pen = 19'sd12800;
    score = 19'sd25600 - pen - 19'sd3 * $signed({4'b0, hl_r})
            - 19'sd2 * $signed({4'b0, sh_r});
    if (contrast8 < 15'd3840) score = score - (19'sd3840 - $signed({4'b0, contrast8}));
    if (score < 0) score = '0;
    if (score > 19'sd25600) score = 19'sd25600;
  end

  logic [14:0] score_r;
  always_ff @(posedge clk) if (cmd.score_calc) score_r <= score[14:0];

  assign mean_o = mean8;
  assign contrast_o = contrast8;
  assign hl_o = hl_r;
  assign sh_o = sh_r;
  assign score_o = score_r;
endmodule
`default_nettype wire

// ===== sv/frame_exposure_statistics_top.sv =====
`default_nettype none
// Frame exposure statistics. Pixels stream in at one beat per clock while a
// frame is being accumulated; the beat with in_tlast ends the frame. The block
// then stops taking pixels while a shared restoring divider (four divisions,
// 48 quotient bits each) and a 16-step bit-pair square root work out the
// result; the next frame's first pixel is taken only once the result beat is
// loaded. The result beat sits in an output register, so the next frame streams
// in while it waits; a frame that finishes before that beat is taken holds in
// its last step until it is.
// Pixels past MAX_FRAME_PIXELS in one frame are not counted. The target
// brightness register is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
module frame_exposure_statistics_top #(
  parameter int unsigned MAX_FRAME_PIXELS = fes_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red, green, blue
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // mean, contrast, highlight, shadow, score, pad
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  fes_pkg::cmd_t cmd;
  fes_pkg::status_t st;
  logic in_fire, out_load;
  logic [7:0] target_r;
  logic [15:0] mean;
  logic [14:0] contrast, hl, sh, score;

  assign in_fire = in_tvalid && in_tready;

  // hold the brightness target
  always_ff @(posedge clk) begin
    if (!rst_n) target_r <= fes_pkg::TARGET_RESET;
    else if (cfg_wr_en) target_r <= cfg_wr_data;
  end

  fes_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_tlast),
    .out_busy(out_tvalid && !out_tready), .st, .cmd, .in_ready(in_tready), .out_load
  );

  fes_datapath #(.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)) u_dp (
    .clk, .rst_n, .cmd, .st,
    .red(in_tdata[7:0]), .green(in_tdata[15:8]), .blue(in_tdata[23:16]),
    .target(target_r), .mean_o(mean), .contrast_o(contrast),
    .hl_o(hl), .sh_o(sh), .score_o(score)
  );

  // output register: load the finished beat, drop valid on handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (out_load) out_tdata <= {4'b0, score, sh, hl, contrast, mean};
  end
endmodule
`default_nettype wire

// ===== sv/fes_checker.sv =====
`default_nettype none
module fes_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall");
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready) else $error("no stop after last");
  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[75:61] <= 15'd25600) else $error("score range");
  a_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[45:31] <= 15'd25600 && out_tdata[60:46] <= 15'd25600)
    else $error("percent range");
endmodule
bind frame_exposure_statistics_top fes_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

// ===== tb/sv/tb_frame_exposure_statistics_top.sv =====
`timescale 1ns / 1ps
module tb_frame_exposure_statistics_top;

  typedef struct packed {
    logic [14:0] score;
    logic [14:0] shadow;
    logic [14:0] highlight;
    logic [14:0] contrast;
    logic [15:0] mean;
  } frame_stats_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red, green, blue
  logic        in_tlast;   // last_pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // mean, contrast, highlight, shadow, score, pad
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  frame_exposure_statistics_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state: frame accumulators and the brightness target.
  logic [7:0]   target_q;
  longint unsigned pix_cnt, luma_acc, luma_sq_acc, bright_cnt, dark_cnt;
  frame_stats_t stats_q[$];
  int           fail_cnt;
  bit           send_gaps;   // sender idles at random when set
  bit           recv_gaps;   // receiver stalls at random when set
  bit           recv_hold;   // receiver holds off entirely when set

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root, probe;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      probe = root | (64'd1 << b);
      if (probe * probe <= x) root = probe;
    end
    return root;
  endfunction

  // floor(num * 2^sh / den) without overflow
  function automatic longint unsigned scaled_quot(longint unsigned num, longint unsigned den,
                                                  int sh);
    return ((num / den) << sh) + (((num % den) << sh) / den);
  endfunction

  // Fold one pixel into the frame; on the last pixel push the frame statistics.
  task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    longint unsigned luma, n, m16, e32, msq, var32, mean8, con8, hl, sh;
    longint score, err, pen;
    frame_stats_t s;
    luma = (64'd19595 * r + 64'd38470 * g + 64'd7471 * b) >> 16;
    if (pix_cnt < fes_pkg::MAX_FRAME_PIXELS_DEF) begin
      pix_cnt++;
      luma_acc += luma;
      luma_sq_acc += luma * luma;
      if (luma >= fes_pkg::BRIGHT_LIMIT) bright_cnt++;
      if (luma <= fes_pkg::DARK_LIMIT) dark_cnt++;
    end
    if (last) begin
      n = (pix_cnt == 0) ? 1 : pix_cnt;
      m16 = scaled_quot(luma_acc, n, 16);
      e32 = scaled_quot(luma_sq_acc, n, 32);
      msq = m16 * m16;
      var32 = (e32 > msq) ? e32 - msq : 0;
      mean8 = m16 >> 8;
      con8 = isqrt(var32 >> 16);
      hl = bright_cnt * 25600 / n;
      sh = dark_cnt * 25600 / n;
      err = longint'(mean8) - (longint'(target_q) << 8);
      if (err < 0) err = -err;
      pen = err * 3 / 2;
      if (pen > 12800) pen = 12800;
      score = 25600 - pen - 3 * longint'(hl) - 2 * longint'(sh);
      if (con8 < 3840) score -= 3840 - longint'(con8);
      if (score < 0) score = 0;
      if (score > 25600) score = 25600;
      s.mean = mean8[15:0];
      s.contrast = con8[14:0];
      s.highlight = hl[14:0];
      s.shadow = sh[14:0];
      s.score = score[14:0];
      stats_q.push_back(s);
      pix_cnt = 0; luma_acc = 0; luma_sq_acc = 0; bright_cnt = 0; dark_cnt = 0;
    end
  endtask

  // Offer one pixel beat, with a random idle ahead of it, and hold until taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    while (send_gaps && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(r, g, b, last);
  endtask

  task automatic send_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain, then give it time to finish a frame still in flight.
  task automatic drain();
    int guard;
    send_idle();
    guard = 0;
    while (stats_q.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_target(logic [7:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_q = val;
  endtask

  task automatic send_random_frame(int len);
    logic [7:0] r, g, b;
    int mode;
    mode = int'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      // bias some frames toward clipped pixels so both counters move
      case (mode)
        0: begin r = 8'($urandom_range(250, 255)); g = 8'($urandom_range(250, 255));
                 b = 8'($urandom_range(250, 255)); end
        1: begin r = 8'($urandom_range(0, 8)); g = 8'($urandom_range(0, 8));
                 b = 8'($urandom_range(0, 8)); end
        default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
      endcase
      send_pixel(r, g, b, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);            // single black pixel
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);      // single white pixel
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);            // half black, half white: max contrast
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd250, 8'd250, 8'd250, 1'b0);      // highlight and shadow edges
    send_pixel(8'd249, 8'd249, 8'd249, 1'b0);
    send_pixel(8'd5, 8'd5, 8'd5, 1'b0);
    send_pixel(8'd6, 8'd6, 8'd6, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    for (int i = 0; i < 8; i++) send_pixel(8'd128, 8'd128, 8'd128, i == 7);  // zero variance
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    drain();
  endtask

  task automatic test_targets();
    logic [7:0] tgts[4];
    tgts = '{8'd0, 8'd255, 8'd1, 8'd128};
    foreach (tgts[k]) begin
      write_target(tgts[k]);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_random_frame(5);
      drain();
    end
  endtask

  task automatic test_random(int pixels);
    int sent, len;
    sent = 0;
    while (sent < pixels) begin
      len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
                                     : int'($urandom_range(1, 8));
      send_random_frame(len);
      sent += len;
      if ($urandom_range(15) == 0) begin
        drain();
        write_target(8'($urandom));
      end
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering frames.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int f = 0; f < 6; f++) send_random_frame(4);
    join
    drain();
  endtask

  task automatic test_no_gaps();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int f = 0; f < 10; f++) send_random_frame(int'($urandom_range(1, 10)));
    drain();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // Drive out_tready: random stalls, or a full hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_hold && !(recv_gaps && $urandom_range(99) < 8);
    end
  end

  // Compare each result beat with the oldest pending frame statistics.
  always @(posedge clk) begin
    frame_stats_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[75:0];
      if (stats_q.size() == 0) begin
        $error("result beat with no frame pending: %h", out_tdata);
        fail_cnt++;
      end else begin
        exp_s = stats_q.pop_front();
        if (got.mean != exp_s.mean) begin
          $error("mean_brightness exp %0d got %0d", exp_s.mean, got.mean); fail_cnt++;
        end
        if (got.contrast != exp_s.contrast) begin
          $error("contrast_level exp %0d got %0d", exp_s.contrast, got.contrast); fail_cnt++;
        end
        if (got.highlight != exp_s.highlight) begin
          $error("highlight_percent exp %0d got %0d", exp_s.highlight, got.highlight);
          fail_cnt++;
        end
        if (got.shadow != exp_s.shadow) begin
          $error("shadow_percent exp %0d got %0d", exp_s.shadow, got.shadow); fail_cnt++;
        end
        if (got.score != exp_s.score) begin
          $error("frame_score exp %0d got %0d", exp_s.score, got.score); fail_cnt++;
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("frame_exposure_statistics_top: mismatch");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    fail_cnt = 0; target_q = fes_pkg::TARGET_RESET;
    pix_cnt = 0; luma_acc = 0; luma_sq_acc = 0; bright_cnt = 0; dark_cnt = 0;
    send_gaps = 1'b1; recv_gaps = 1'b1; recv_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_targets();
    test_backpressure();
    test_no_gaps();
    test_random(600);
    if (stats_q.size() != 0) begin
      $error("%0d frame results never arrived", stats_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("frame_exposure_statistics_top: match");
    end else begin
      $display("frame_exposure_statistics_top: mismatch");
    end
    $finish;
  end
endmodule
